### rtl/psg_pkg.sv
`timescale 1ns / 1ps

package psg_pkg;

    // Default fraction width of the chip-cycle accumulator
    localparam int FRACTION_BITS_DEF = 16;

    // Config register indexes
    localparam logic CFG_CYCLE_INC = 1'b0;
    localparam logic CFG_FRAME_DIV = 1'b1;

    localparam logic [23:0] CYCLE_INC_RST = 24'd2659738;
    localparam logic [9:0]  FRAME_DIV_RST = 10'd74;

    // Item kinds carried in tuser
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Channel numbers, also the upper bits of the control byte address
    localparam logic [1:0] CH_PULSE0 = 2'd0;
    localparam logic [1:0] CH_PULSE1 = 2'd1;
    localparam logic [1:0] CH_TRI    = 2'd2;
    localparam logic [1:0] CH_NOISE  = 2'd3;

    // Special register addresses
    localparam logic [4:0] ADDR_TRI_LEN = 5'd11;
    localparam logic [4:0] ADDR_ENABLE  = 5'd21;
    localparam logic [3:0] ADDR_TRI_R0  = 4'd8;

    function automatic logic [7:0] len_lookup(input logic [4:0] idx);
        logic [7:0] v;
        unique case (idx)
            5'd0:  v = 8'd10;  5'd1:  v = 8'd254; 5'd2:  v = 8'd20;  5'd3:  v = 8'd2;
            5'd4:  v = 8'd40;  5'd5:  v = 8'd4;   5'd6:  v = 8'd80;  5'd7:  v = 8'd6;
            5'd8:  v = 8'd160; 5'd9:  v = 8'd8;   5'd10: v = 8'd60;  5'd11: v = 8'd10;
            5'd12: v = 8'd14;  5'd13: v = 8'd12;  5'd14: v = 8'd26;  5'd15: v = 8'd14;
            5'd16: v = 8'd12;  5'd17: v = 8'd16;  5'd18: v = 8'd24;  5'd19: v = 8'd18;
            5'd20: v = 8'd48;  5'd21: v = 8'd20;  5'd22: v = 8'd96;  5'd23: v = 8'd22;
            5'd24: v = 8'd192; 5'd25: v = 8'd24;  5'd26: v = 8'd72;  5'd27: v = 8'd26;
            5'd28: v = 8'd16;  5'd29: v = 8'd28;  5'd30: v = 8'd32;  default: v = 8'd30;
        endcase
        return v;
    endfunction

    function automatic logic [11:0] period_limit(input logic [2:0] idx);
        logic [11:0] v;
        unique case (idx)
            3'd0: v = 12'h3FF; 3'd1: v = 12'h555; 3'd2: v = 12'h666; 3'd3: v = 12'h71C;
            3'd4: v = 12'h787; 3'd5: v = 12'h7C1; 3'd6: v = 12'h7E0; default: v = 12'h7F2;
        endcase
        return v;
    endfunction

    function automatic logic [11:0] noise_period(input logic [3:0] idx);
        logic [11:0] v;
        unique case (idx)
            4'd0:  v = 12'd4;    4'd1:  v = 12'd8;    4'd2:  v = 12'd16;   4'd3:  v = 12'd32;
            4'd4:  v = 12'd64;   4'd5:  v = 12'd96;   4'd6:  v = 12'd128;  4'd7:  v = 12'd160;
            4'd8:  v = 12'd202;  4'd9:  v = 12'd254;  4'd10: v = 12'd380;  4'd11: v = 12'd508;
            4'd12: v = 12'd762;  4'd13: v = 12'd1016; 4'd14: v = 12'd2034; default: v = 12'd4068;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] duty_pattern(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0: v = 8'h40; 2'd1: v = 8'h60; 2'd2: v = 8'h78; default: v = 8'h9F;
        endcase
        return v;
    endfunction

    // Envelope step: loop flag wraps, else saturates at 15
    function automatic logic [3:0] env_advance(input logic [3:0] level, input logic [7:0] ctrl);
        logic [3:0] v;
        if (ctrl[5]) begin
            v = level + 4'd1;
        end else begin
            v = (level != 4'd15) ? level + 4'd1 : level;
        end
        return v;
    endfunction

    // Signed level of a volume, positive or negative
    function automatic logic signed [4:0] signed_vol(input logic [3:0] vol, input logic pos);
        logic signed [4:0] v;
        v = $signed({1'b0, vol});
        return pos ? v : -v;
    endfunction

endpackage

### rtl/psg_ram.sv
`timescale 1ns / 1ps

module psg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/four_channel_psg_synth.sv
`timescale 1ns / 1ps

// Four-channel sound generator (two pulse, one triangle, one noise). Each input
// beat is a register write (tuser = 0) or a render tick (tuser = 1); only render
// ticks give an output beat, the mixed signed sample times 4. A write to the
// triangle length register takes an extra state to read the linear reload byte.
// A render tick walks the four channels in turn: fetch a channel's control bytes
// from the control RAM, update counters, then the serial phase/period divide on
// pulse and triangle channels, or for noise one LFSR shift per whole period in
// the phase (up to 16383 shifts); then the mix. A tick with no whole chip cycles
// goes straight to the mix. Control bytes sit in a 16x8 RAM whose entries read as
// zero until first written after reset. Config writes are taken at any time.
module four_channel_psg_synth #(
    parameter int FRACTION_BITS = psg_pkg::FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [4:0] reg_addr, [12:5] write_data, [15:13] zero
    input  logic [0:0]  s_tuser,   // [0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [8:0] sample, [15:9] zero
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_addr,
    input  logic [23:0] cfg_data
);

    localparam int SUMW = FRACTION_BITS + 16;

    typedef enum logic [2:0] {
        ST_IDLE, ST_WR_TRI, ST_RD, ST_EXEC, ST_DIV, ST_FIN, ST_NOISE, ST_MIX
    } state_t;

    state_t state_reg;

    logic [23:0] cycle_inc_reg;
    logic [9:0]  frame_div_reg;
    logic [FRACTION_BITS-1:0] frac_reg;
    logic [9:0]  frame_cnt_reg;
    logic [15:0] cycles_reg;
    logic        frame_reg;
    logic [3:0]  enable_reg;

    logic [15:0] pulse_phase_reg [2];
    logic [3:0]  pulse_step_reg  [2];
    logic [3:0]  pulse_env_reg   [2];
    logic [7:0]  pulse_len_reg   [2];
    logic signed [4:0] pulse_out_reg [2];
    logic [2:0]  sweep_cnt_reg;

    logic [15:0] tri_phase_reg;
    logic [4:0]  tri_step_reg;
    logic [7:0]  tri_lin_reg;
    logic [3:0]  tri_flags_reg;
    logic [7:0]  tri_len_reg;
    logic signed [4:0] tri_out_reg;

    logic [14:0] noise_shift_reg;
    logic [15:0] noise_phase_reg;
    logic [3:0]  noise_env_reg;
    logic [7:0]  noise_len_reg;
    logic signed [4:0] noise_out_reg;

    logic [1:0]  ch_reg;
    logic [2:0]  idx_reg;
    logic [7:0]  r_reg [4];
    logic [7:0]  tri_wr_data_reg;

    logic [15:0] div_num_reg;
    logic [11:0] div_den_reg;
    logic [11:0] div_rem_reg;
    logic [15:0] div_q_reg;
    logic [3:0]  div_cnt_reg;

    logic        m_valid_reg;
    logic [8:0]  sample_reg;

    // control byte RAM, valid bits make unwritten entries read as zero
    logic [15:0] ctrl_valid_reg;
    logic        rd_valid_reg;
    logic        ram_wr_en;
    logic [3:0]  ram_rd_addr;
    logic [7:0]  ram_rd_data;
    logic [7:0]  ctrl_byte;

    logic        s_accept;
    logic [4:0]  in_addr;
    logic [7:0]  in_data;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_addr   = s_tdata[4:0];
    assign in_data   = s_tdata[12:5];
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {7'd0, sample_reg};

    assign ram_wr_en = s_accept && (s_tuser[0] == psg_pkg::OP_WRITE) && !in_addr[4];
    assign ctrl_byte = rd_valid_reg ? ram_rd_data : 8'd0;

    always_comb begin
        unique case (state_reg)
            ST_IDLE: ram_rd_addr = psg_pkg::ADDR_TRI_R0;
            ST_RD:   ram_rd_addr = {ch_reg, idx_reg[1:0]};
            default: ram_rd_addr = '0;
        endcase
    end

    psg_ram #(.WIDTH(8), .DEPTH(16)) u_ctrl_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (in_addr[3:0]),
        .wr_data (in_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // divider trial subtraction
    logic [12:0] div_trial;
    logic        div_ge;
    assign div_trial = {div_rem_reg, div_num_reg[15]};
    assign div_ge    = div_trial >= {1'b0, div_den_reg};

    // mix: 3/4 weighting floors, which is an arithmetic shift
    logic signed [6:0] tri_w3, noise_w3;
    logic signed [9:0] mix_sum;
    assign tri_w3   = 7'(tri_out_reg) * 7'sd3;
    assign noise_w3 = 7'(noise_out_reg) * 7'sd3;
    assign mix_sum  = 10'(pulse_out_reg[0]) + 10'(pulse_out_reg[1])
                    + 10'(tri_w3 >>> 2) + 10'(noise_w3 >>> 2);

    always_ff @(posedge aclk) begin
        logic [SUMW-1:0] sum_v;
        logic [9:0]  fc_v;
        logic        pi;
        logic [7:0]  len_v;
        logic [7:0]  lin_v;
        logic [3:0]  flags_v;
        logic [1:0]  lat_v;
        logic [11:0] per_v;
        logic [3:0]  cnt_v;
        logic [3:0]  pstep_v;
        logic [4:0]  tstep_v;
        logic [3:0]  o_v;
        logic [2:0]  bit_v;
        logic [3:0]  vol_v;
        logic [7:0]  duty_v;
        logic        fb_v;
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cycle_inc_reg   <= psg_pkg::CYCLE_INC_RST;
            frame_div_reg   <= psg_pkg::FRAME_DIV_RST;
            frac_reg        <= '0;
            frame_cnt_reg   <= '0;
            enable_reg      <= '0;
            for (int i = 0; i < 2; i++) begin
                pulse_phase_reg[i] <= '0;
                pulse_step_reg[i]  <= '0;
                pulse_env_reg[i]   <= '0;
                pulse_len_reg[i]   <= '0;
                pulse_out_reg[i]   <= '0;
            end
            sweep_cnt_reg   <= '0;
            tri_phase_reg   <= '0;
            tri_step_reg    <= '0;
            tri_lin_reg     <= '0;
            tri_flags_reg   <= '0;
            tri_len_reg     <= '0;
            tri_out_reg     <= '0;
            noise_shift_reg <= 15'd1;
            noise_phase_reg <= '0;
            noise_env_reg   <= '0;
            noise_len_reg   <= '0;
            noise_out_reg   <= '0;
            ctrl_valid_reg  <= '0;
            rd_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            ch_reg          <= '0;
            idx_reg         <= '0;
        end else begin
            rd_valid_reg <= ctrl_valid_reg[ram_rd_addr];
            if (ram_wr_en) begin
                ctrl_valid_reg[in_addr[3:0]] <= 1'b1;
            end

            // config writes
            if (cfg_valid) begin
                unique case (cfg_addr[0])
                    psg_pkg::CFG_CYCLE_INC: cycle_inc_reg <= cfg_data;
                    default:                frame_div_reg <= cfg_data[9:0];
                endcase
            end

            // the mix step loads the next beat itself
            if (m_valid_reg && m_tready && state_reg != ST_MIX) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser[0] == psg_pkg::OP_RENDER) begin
                            // fractional cycle accumulator and frame divider
                            sum_v = SUMW'(frac_reg) + SUMW'(cycle_inc_reg);
                            frac_reg   <= sum_v[FRACTION_BITS-1:0];
                            cycles_reg <= sum_v[SUMW-1 -: 16];
                            fc_v = frame_cnt_reg + 10'd1;
                            if (fc_v >= frame_div_reg) begin
                                frame_cnt_reg <= '0;
                                frame_reg     <= 1'b1;
                            end else begin
                                frame_cnt_reg <= fc_v;
                                frame_reg     <= 1'b0;
                            end
                            ch_reg  <= psg_pkg::CH_PULSE0;
                            idx_reg <= '0;
                            state_reg <= (sum_v[SUMW-1 -: 16] == 16'd0) ? ST_MIX : ST_RD;
                        end else if (in_addr < 5'd8) begin
                            pi = in_addr[2];
                            if (in_addr[1:0] == 2'd3 && enable_reg[pi]) begin
                                pulse_len_reg[pi] <= psg_pkg::len_lookup(in_data[7:3]);
                                pulse_env_reg[pi] <= '0;
                            end
                        end else if (in_addr == psg_pkg::ADDR_TRI_LEN) begin
                            // needs the linear reload byte, read this cycle
                            tri_wr_data_reg <= in_data;
                            state_reg <= ST_WR_TRI;
                        end else if (in_addr < 5'd16) begin
                            if (in_addr[1:0] == 2'd3 && enable_reg[3]) begin
                                noise_len_reg <= psg_pkg::len_lookup(in_data[7:3]);
                                noise_env_reg <= '0;
                            end
                        end else if (in_addr == psg_pkg::ADDR_ENABLE) begin
                            enable_reg <= in_data[3:0];
                            if (!in_data[0]) pulse_len_reg[0] <= '0;
                            if (!in_data[1]) pulse_len_reg[1] <= '0;
                            if (!in_data[2]) begin
                                tri_len_reg      <= '0;
                                tri_lin_reg      <= '0;
                                tri_flags_reg[3] <= 1'b0;
                            end
                            if (!in_data[3]) noise_len_reg <= '0;
                        end
                    end
                end

                ST_WR_TRI: begin
                    flags_v = tri_flags_reg;
                    flags_v[1:0] = 2'd3;
                    if (enable_reg[2]) begin
                        tri_len_reg <= psg_pkg::len_lookup(tri_wr_data_reg[7:3]);
                        tri_lin_reg <= {1'b0, ctrl_byte[6:0]} + 8'd1;
                        flags_v[2] = 1'b1;
                    end
                    tri_flags_reg <= flags_v;
                    state_reg <= ST_IDLE;
                end

                // fetch four control bytes of the current channel
                ST_RD: begin
                    if (idx_reg != 3'd0) begin
                        r_reg[2'(idx_reg - 3'd1)] <= ctrl_byte;
                    end
                    if (idx_reg == 3'd4) begin
                        state_reg <= ST_EXEC;
                    end else begin
                        idx_reg <= idx_reg + 3'd1;
                    end
                end

                ST_EXEC: begin
                    idx_reg <= '0;
                    unique case (ch_reg)
                        psg_pkg::CH_TRI: begin
                            flags_v = tri_flags_reg;
                            lin_v   = tri_lin_reg;
                            len_v   = tri_len_reg;
                            if (!enable_reg[2]) begin
                                tri_out_reg <= '0;
                                ch_reg <= ch_reg + 2'd1;
                                state_reg <= ST_RD;
                            end else begin
                                if (frame_reg) begin
                                    if (!flags_v[3]) begin
                                        lat_v = flags_v[1:0];
                                        if (lat_v != 2'd0) lat_v = lat_v - 2'd1;
                                        flags_v[1:0] = lat_v;
                                        if (lat_v == 2'd0) flags_v[3] = 1'b1;
                                    end
                                    if (flags_v[3]) begin
                                        if (flags_v[2]) lin_v = {1'b0, r_reg[0][6:0]} + 8'd1;
                                        else if (lin_v != 8'd0) lin_v = lin_v - 8'd1;
                                        if (!r_reg[0][7]) begin
                                            flags_v[2] = 1'b0;
                                            if (len_v != 8'd0) len_v = len_v - 8'd1;
                                        end
                                    end
                                end
                                tri_flags_reg <= flags_v;
                                tri_lin_reg   <= lin_v;
                                tri_len_reg   <= len_v;
                                per_v = {1'b0, r_reg[3][2:0], r_reg[2]} + 12'd1;
                                if (lin_v == 8'd0 || len_v == 8'd0 || per_v < 12'd4) begin
                                    tri_out_reg <= '0;
                                    ch_reg <= ch_reg + 2'd1;
                                    state_reg <= ST_RD;
                                end else begin
                                    div_num_reg <= tri_phase_reg + cycles_reg;
                                    div_den_reg <= per_v;
                                    div_rem_reg <= '0;
                                    div_cnt_reg <= '0;
                                    state_reg   <= ST_DIV;
                                end
                            end
                        end
                        psg_pkg::CH_NOISE: begin
                            len_v = noise_len_reg;
                            if (!enable_reg[3]) begin
                                noise_out_reg <= '0;
                                state_reg <= ST_MIX;
                            end else begin
                                if (frame_reg && !r_reg[0][5] && len_v != 8'd0) begin
                                    len_v = len_v - 8'd1;
                                end
                                noise_len_reg <= len_v;
                                // envelope steps on a frame even when the length ran out
                                if (frame_reg && !r_reg[0][4]) begin
                                    noise_env_reg <= psg_pkg::env_advance(noise_env_reg,
                                                                          r_reg[0]);
                                end
                                if (len_v == 8'd0) begin
                                    noise_out_reg <= '0;
                                    state_reg <= ST_MIX;
                                end else begin
                                    noise_phase_reg <= noise_phase_reg + cycles_reg;
                                    state_reg <= ST_NOISE;
                                end
                            end
                        end
                        default: begin
                            // pulse channels
                            pi = ch_reg[0];
                            len_v = pulse_len_reg[pi];
                            if (!enable_reg[pi]) begin
                                pulse_out_reg[pi] <= '0;
                                ch_reg <= ch_reg + 2'd1;
                                state_reg <= ST_RD;
                            end else begin
                                if (frame_reg && !r_reg[0][5] && len_v != 8'd0) begin
                                    len_v = len_v - 8'd1;
                                end
                                pulse_len_reg[pi] <= len_v;
                                per_v = {1'b0, r_reg[3][2:0], r_reg[2]} + 12'd1;
                                // sweep on pulse 0 only, for this tick only
                                if (!pi && r_reg[1][7] && r_reg[1][2:0] != 3'd0 && frame_reg
                                    && len_v != 8'd0) begin
                                    cnt_v = {1'b0, sweep_cnt_reg} + 4'd1;
                                    if (cnt_v >= {1'b0, r_reg[1][6:4]} + 4'd1) begin
                                        cnt_v = '0;
                                        if (r_reg[1][3]) per_v = per_v - (per_v >> r_reg[1][2:0]);
                                        else             per_v = per_v + (per_v >> r_reg[1][2:0]);
                                    end
                                    sweep_cnt_reg <= cnt_v[2:0];
                                end
                                if (len_v == 8'd0) begin
                                    pulse_out_reg[pi] <= '0;
                                    ch_reg <= ch_reg + 2'd1;
                                    state_reg <= ST_RD;
                                end else begin
                                    if (frame_reg && !r_reg[0][4]) begin
                                        pulse_env_reg[pi] <= psg_pkg::env_advance(
                                            pulse_env_reg[pi], r_reg[0]);
                                    end
                                    if (per_v < 12'd4
                                        || per_v > psg_pkg::period_limit(r_reg[1][2:0])) begin
                                        pulse_out_reg[pi] <= '0;
                                        ch_reg <= ch_reg + 2'd1;
                                        state_reg <= ST_RD;
                                    end else begin
                                        div_num_reg <= pulse_phase_reg[pi] + cycles_reg;
                                        div_den_reg <= per_v;
                                        div_rem_reg <= '0;
                                        div_cnt_reg <= '0;
                                        state_reg   <= ST_DIV;
                                    end
                                end
                            end
                        end
                    endcase
                end

                // restoring divide, one quotient bit a cycle
                ST_DIV: begin
                    div_rem_reg <= div_ge ? 12'(div_trial - {1'b0, div_den_reg})
                                          : div_trial[11:0];
                    div_q_reg   <= {div_q_reg[14:0], div_ge};
                    div_num_reg <= {div_num_reg[14:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_cnt_reg == 4'd15) begin
                        state_reg <= ST_FIN;
                    end
                end

                ST_FIN: begin
                    ch_reg <= ch_reg + 2'd1;
                    state_reg <= ST_RD;
                    if (ch_reg == psg_pkg::CH_TRI) begin
                        tri_phase_reg <= {4'd0, div_rem_reg};
                        if (div_q_reg != 16'd0) begin
                            tstep_v = tri_step_reg + div_q_reg[4:0];
                            tri_step_reg <= tstep_v;
                            o_v = tstep_v[3:0] ^ (tstep_v[3] ? 4'd7 : 4'd8);
                            if (tstep_v[4]) o_v = o_v ^ 4'd15;
                            tri_out_reg <= $signed({o_v, 1'b0}) - 5'sd16;
                        end
                    end else begin
                        pi = ch_reg[0];
                        pulse_phase_reg[pi] <= {4'd0, div_rem_reg};
                        pstep_v = pulse_step_reg[pi] + div_q_reg[3:0];
                        pulse_step_reg[pi] <= pstep_v;
                        vol_v = r_reg[0][4] ? r_reg[0][3:0] : 4'd15 - pulse_env_reg[pi];
                        bit_v = 3'd7 - pstep_v[3:1];
                        duty_v = psg_pkg::duty_pattern(r_reg[0][7:6]);
                        pulse_out_reg[pi] <= psg_pkg::signed_vol(vol_v, duty_v[bit_v]);
                    end
                end

                // one LFSR shift per whole noise period in the phase
                ST_NOISE: begin
                    per_v = psg_pkg::noise_period(r_reg[2][3:0]);
                    if (noise_phase_reg >= {4'd0, per_v}) begin
                        noise_phase_reg <= noise_phase_reg - {4'd0, per_v};
                        fb_v = noise_shift_reg[0]
                             ^ (r_reg[2][7] ? noise_shift_reg[6] : noise_shift_reg[1]);
                        noise_shift_reg <= {fb_v, noise_shift_reg[14:1]};
                    end else begin
                        vol_v = r_reg[0][4] ? r_reg[0][3:0] : 4'd15 - noise_env_reg;
                        noise_out_reg <= psg_pkg::signed_vol(vol_v, noise_shift_reg[0]);
                        state_reg <= ST_MIX;
                    end
                end

                ST_MIX: begin
                    if (!m_valid_reg || m_tready) begin
                        sample_reg  <= 9'(mix_sum <<< 2);
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // LFSR never locks up in the all-zero state
    a_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        noise_shift_reg != 15'd0)
        else $error("noise LFSR reached zero");

    // divider leaves a remainder below the period
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> (div_rem_reg < div_den_reg))
        else $error("divider remainder not below period");

    // triangle level stays on its 16-step ramp
    a_tri_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (tri_out_reg >= -5'sd16) && (tri_out_reg <= 5'sd14) && !tri_out_reg[0])
        else $error("triangle output off its ramp");

    // a result is produced only at the end of a render pass
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_MIX))
        else $error("result raised outside mix step");
`endif

endmodule
